// ----- design/cla_pkg.sv -----
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types, register map and reset values of the charge LED animator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cla_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LVL_W  = 8;

  // reset values of the configuration registers
  localparam logic [LVL_W-1:0] RST_EVAL_PERIOD      = 8'd10;
  localparam logic [LVL_W-1:0] RST_FADE_STEP        = 8'd8;
  localparam logic [LVL_W-1:0] RST_FADE_STEPS       = 8'd16;
  localparam logic [LVL_W-1:0] RST_BLINK_COUNT      = 8'd50;
  localparam logic [LVL_W-1:0] RST_FADE_START_LEVEL = 8'd0;
  localparam logic [LVL_W-1:0] RST_DONE_LEVEL       = 8'd255;
  localparam logic [LVL_W-1:0] RST_BLINK_LEVEL      = 8'd255;

  typedef enum logic [2:0] {
    REG_EVAL_PERIOD      = 3'd0,
    REG_FADE_STEP        = 3'd1,
    REG_FADE_STEPS       = 3'd2,
    REG_BLINK_COUNT      = 3'd3,
    REG_FADE_START_LEVEL = 3'd4,
    REG_DONE_LEVEL       = 3'd5,
    REG_BLINK_LEVEL      = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OFF      = 2'd0,
    STATUS_CHARGING = 2'd1,
    STATUS_DONE     = 2'd2,
    STATUS_FAULT    = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    MODE_OFF       = 6'b000001,
    MODE_DONE      = 6'b000010,
    MODE_FADE_UP   = 6'b000100,
    MODE_FADE_DOWN = 6'b001000,
    MODE_BLINK_ON  = 6'b010000,
    MODE_BLINK_OFF = 6'b100000
  } mode_t;

  typedef enum logic {
    ACT_TICK      = 1'b0,
    ACT_BL_ENABLE = 1'b1
  } action_t;

  typedef struct packed {
    logic [LVL_W-1:0] eval_period;
    logic [LVL_W-1:0] fade_step;
    logic [LVL_W-1:0] fade_steps;
    logic [LVL_W-1:0] blink_count;
    logic [LVL_W-1:0] fade_start_level;
    logic [LVL_W-1:0] done_level;
    logic [LVL_W-1:0] blink_level;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [1:0]       charge_status;
    logic [LVL_W-1:0] backlight_request;
    logic             backlight_enable;
  } item_t;

  typedef struct packed {
    logic [LVL_W-1:0] charge_level;
    logic             charge_on;
    logic [LVL_W-1:0] backlight_level;
    logic             backlight_on;
  } res_t;

endpackage

`default_nettype wire

// ----- design/cla_if.sv -----
// ----------------------------------------------------------------------------
// cla_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cla_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [1:0] charge_status;
  logic [7:0] backlight_request;
  logic       backlight_enable;

  modport source (output valid, action, charge_status, backlight_request,
                  backlight_enable, input ready);
  modport sink   (input valid, action, charge_status, backlight_request,
                  backlight_enable, output ready);
endinterface

interface cla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] charge_level;
  logic       charge_on;
  logic [7:0] backlight_level;
  logic       backlight_on;

  modport source (output valid, charge_level, charge_on, backlight_level,
                  backlight_on, input ready);
  modport sink   (input valid, charge_level, charge_on, backlight_level,
                  backlight_on, output ready);
endinterface

`default_nettype wire

// ----- design/charge_led_animator_top.sv -----
// ----------------------------------------------------------------------------
// charge_led_animator_top
// Charge and backlight LED level generator with APB configuration.
// ----------------------------------------------------------------------------
// Takes one input transaction every clock cycle while the skid register is
// empty. Each transaction (a 1 ms tick or a backlight enable change) updates
// the prescaler and animation state and produces one result transaction in
// the output register, or in a one-entry skid register while the output is
// stalled, so the input keeps flowing while one result waits. The state update
// is the only work per item; throughput is one per cycle with the skid empty.
// Registers sit at byte address 4*index and should be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module charge_led_animator_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  cla_in_if.sink                          in_ch,
  cla_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cla_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cla_pkg::DATA_W-1:0] pwdata,
  output logic      [cla_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import cla_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  out_r;
  res_t  skid_r;
  logic  out_valid_r;
  logic  skid_valid_r;
  logic  push;
  logic  pop;

  cla_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.action            = in_ch.action;
  assign item.charge_status     = in_ch.charge_status;
  assign item.backlight_request = in_ch.backlight_request;
  assign item.backlight_enable  = in_ch.backlight_enable;

  assign in_ch.ready = !skid_valid_r;
  assign push        = in_ch.valid && !skid_valid_r;
  assign pop         = out_valid_r && out_ch.ready;

  cla_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (push),
    .item   (item),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.charge_level    = out_r.charge_level;
  assign out_ch.charge_on       = out_r.charge_on;
  assign out_ch.backlight_level = out_r.backlight_level;
  assign out_ch.backlight_on    = out_r.backlight_on;

  // skid entry only ever holds a result behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register filled while output empty");

  // a transaction against a stalled output lands in the skid register
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result lost on stalled output");

  // a transaction into an empty or draining buffer shows up next cycle
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("result not presented");

endmodule

`default_nettype wire

// ----- design/cla_regs.sv -----
// ----------------------------------------------------------------------------
// cla_regs
// APB configuration register file of the charge LED animator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cla_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cla_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cla_pkg::DATA_W-1:0] pwdata,
  output logic      [cla_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output cla_pkg::cfg_t                  cfg
);
  import cla_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;
  logic [LVL_W-1:0] wr_val;
  logic [LVL_W-1:0] rd_val;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[LVL_W-1:0];
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_EVAL_PERIOD:      cfg_nxt.eval_period      = wr_val;
        REG_FADE_STEP:        cfg_nxt.fade_step        = wr_val;
        REG_FADE_STEPS:       cfg_nxt.fade_steps       = wr_val;
        REG_BLINK_COUNT:      cfg_nxt.blink_count      = wr_val;
        REG_FADE_START_LEVEL: cfg_nxt.fade_start_level = wr_val;
        REG_DONE_LEVEL:       cfg_nxt.done_level       = wr_val;
        REG_BLINK_LEVEL:      cfg_nxt.blink_level      = wr_val;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EVAL_PERIOD:      rd_val = cfg_r.eval_period;
      REG_FADE_STEP:        rd_val = cfg_r.fade_step;
      REG_FADE_STEPS:       rd_val = cfg_r.fade_steps;
      REG_BLINK_COUNT:      rd_val = cfg_r.blink_count;
      REG_FADE_START_LEVEL: rd_val = cfg_r.fade_start_level;
      REG_DONE_LEVEL:       rd_val = cfg_r.done_level;
      REG_BLINK_LEVEL:      rd_val = cfg_r.blink_level;
      default:              rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-LVL_W){1'b0}}, rd_val};
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eval_period      <= RST_EVAL_PERIOD;
      cfg_r.fade_step        <= RST_FADE_STEP;
      cfg_r.fade_steps       <= RST_FADE_STEPS;
      cfg_r.blink_count      <= RST_BLINK_COUNT;
      cfg_r.fade_start_level <= RST_FADE_START_LEVEL;
      cfg_r.done_level       <= RST_DONE_LEVEL;
      cfg_r.blink_level      <= RST_BLINK_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/cla_core.sv -----
// ----------------------------------------------------------------------------
// cla_core
// Prescaler, charge status, LED animation state; one accepted item a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cla_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire cla_pkg::item_t item,
  input  wire cla_pkg::cfg_t  cfg,
  output cla_pkg::res_t       res
);
  import cla_pkg::*;

  logic [LVL_W-1:0] pres_r,   pres_nxt;
  mode_t            mode_r,   mode_nxt;
  logic [LVL_W-1:0] anim_r,   anim_nxt;
  logic [LVL_W-1:0] fade_r,   fade_nxt;
  logic [1:0]       last_r,   last_nxt;
  logic [LVL_W-1:0] chg_r,    chg_nxt;
  logic [LVL_W-1:0] bl_r,     bl_nxt;
  logic             bl_en_r,  bl_en_nxt;

  always_comb begin
    logic [LVL_W-1:0] pres_dec;
    logic [LVL_W-1:0] cnt_dec;
    mode_t            mode_e;
    logic [LVL_W-1:0] anim_e;
    logic [LVL_W-1:0] fade_e;
    logic [LVL_W-1:0] chg_e;

    pres_nxt  = pres_r;
    mode_nxt  = mode_r;
    anim_nxt  = anim_r;
    fade_nxt  = fade_r;
    last_nxt  = last_r;
    chg_nxt   = chg_r;
    bl_nxt    = bl_r;
    bl_en_nxt = bl_en_r;
    pres_dec  = pres_r - 1'b1;
    mode_e    = mode_r;
    anim_e    = anim_r;
    fade_e    = fade_r;
    chg_e     = chg_r;
    cnt_dec   = '0;

    if (action_t'(item.action) == ACT_BL_ENABLE) begin
      bl_en_nxt = item.backlight_enable;
      bl_nxt    = item.backlight_enable ? item.backlight_request : '0;
    end else if (pres_dec != '0) begin
      pres_nxt = pres_dec;
    end else begin
      pres_nxt = cfg.eval_period;
      if (bl_en_r) begin
        bl_nxt = item.backlight_request;
      end

      // mode entry on a status change
      if (item.charge_status != last_r) begin
        last_nxt = item.charge_status;
        unique case (status_t'(item.charge_status))
          STATUS_OFF: begin
            mode_e = MODE_OFF;
            chg_e  = '0;
          end
          STATUS_CHARGING: begin
            mode_e = MODE_FADE_UP;
            anim_e = cfg.fade_steps;
            fade_e = cfg.fade_start_level;
            chg_e  = cfg.fade_start_level;
          end
          STATUS_DONE: begin
            mode_e = MODE_DONE;
            chg_e  = cfg.done_level;
          end
          STATUS_FAULT: begin
            mode_e = MODE_BLINK_ON;
            anim_e = cfg.blink_count;
            chg_e  = cfg.blink_level;
          end
          default: mode_e = mode_r;
        endcase
      end

      // animation step
      mode_nxt = mode_e;
      anim_nxt = anim_e;
      fade_nxt = fade_e;
      chg_nxt  = chg_e;
      cnt_dec  = anim_e - 1'b1;
      unique case (mode_e)
        MODE_FADE_UP, MODE_FADE_DOWN: begin
          fade_nxt = (mode_e == MODE_FADE_UP) ? fade_e + cfg.fade_step
                                              : fade_e - cfg.fade_step;
          chg_nxt  = fade_nxt;
          anim_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            anim_nxt = cfg.fade_steps;
            mode_nxt = (mode_e == MODE_FADE_UP) ? MODE_FADE_DOWN : MODE_FADE_UP;
          end
        end
        MODE_BLINK_ON: begin
          anim_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            mode_nxt = MODE_BLINK_OFF;
            anim_nxt = cfg.blink_count;
            chg_nxt  = '0;
          end
        end
        MODE_BLINK_OFF: begin
          anim_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            mode_nxt = MODE_BLINK_ON;
            anim_nxt = cfg.blink_count;
            chg_nxt  = cfg.blink_level;
          end
        end
        default: mode_nxt = mode_e;
      endcase
    end
  end

  assign res.charge_level    = chg_nxt;
  assign res.charge_on       = |chg_nxt;
  assign res.backlight_level = bl_nxt;
  assign res.backlight_on    = |bl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r  <= RST_EVAL_PERIOD;
      mode_r  <= MODE_OFF;
      anim_r  <= RST_BLINK_COUNT;
      fade_r  <= '0;
      last_r  <= STATUS_OFF;
      chg_r   <= '0;
      bl_r    <= '0;
      bl_en_r <= 1'b0;
    end else if (accept) begin
      pres_r  <= pres_nxt;
      mode_r  <= mode_nxt;
      anim_r  <= anim_nxt;
      fade_r  <= fade_nxt;
      last_r  <= last_nxt;
      chg_r   <= chg_nxt;
      bl_r    <= bl_nxt;
      bl_en_r <= bl_en_nxt;
    end
  end

  // prescaler reloads from the register on expiry
  a_pres_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !item.action && pres_r == 8'd1) |=> (pres_r == $past(cfg.eval_period)))
    else $error("prescaler did not reload");

  // disabling the backlight blanks it
  a_bl_off: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && item.action && !item.backlight_enable) |=> (bl_r == '0 && !bl_en_r))
    else $error("backlight not blanked on disable");

  // ticks before expiry leave the charge animation alone
  a_anim_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !item.action && pres_r != 8'd1) |=> ($stable(mode_r) && $stable(chg_r)))
    else $error("animation moved without prescaler expiry");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the charge LED animator. A short table of directed
// transactions comes first: extremes, every status and the backlight enable.
// Random phases with their own register settings follow; both channels idle
// at random. Results are checked field by field against the row's expected
// result or a cycle-free model of prescaler, backlight and charge animation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cla_pkg::*;

  localparam int DIR_ROWS    = 17;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic       is_write;
    reg_idx_t   reg_sel;
    logic [7:0] wval;
    item_t      txn;
    logic [3:0] reps;
    logic       has_exp;
    res_t       exp_res;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_BL_ENABLE, STATUS_OFF, 8'hFF, 1'b1},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'hFF, 1'b1}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_BL_ENABLE, STATUS_OFF, 8'h00, 1'b1},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_BL_ENABLE, STATUS_FAULT, 8'h80, 1'b0},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_BL_ENABLE, STATUS_OFF, 8'h01, 1'b1},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'd1, 1'b1}},
    '{1'b1, REG_EVAL_PERIOD, 8'd1, '{ACT_TICK, STATUS_OFF, 8'h00, 1'b0},
      4'd0, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b1, REG_FADE_STEPS, 8'd2, '{ACT_TICK, STATUS_OFF, 8'h00, 1'b0},
      4'd0, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    // prescaler still runs from its reset count
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_FAULT, 8'hFF, 1'b0},
      4'd9, 1'b1, '{8'd0, 1'b0, 8'd1, 1'b1}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_FAULT, 8'hFF, 1'b0},
      4'd1, 1'b1, '{8'hFF, 1'b1, 8'hFF, 1'b1}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_CHARGING, 8'h00, 1'b0},
      4'd1, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    // fade reverses after two evaluations
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_CHARGING, 8'h7F, 1'b1},
      4'd3, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_DONE, 8'h7F, 1'b0},
      4'd1, 1'b1, '{8'hFF, 1'b1, 8'h7F, 1'b1}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_OFF, 8'h00, 1'b0},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b1, REG_BLINK_COUNT, 8'd1, '{ACT_TICK, STATUS_OFF, 8'h00, 1'b0},
      4'd0, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_FAULT, 8'h55, 1'b1},
      4'd3, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b1, REG_DONE_LEVEL, 8'd0, '{ACT_TICK, STATUS_OFF, 8'h00, 1'b0},
      4'd0, 1'b0, '{8'd0, 1'b0, 8'd0, 1'b0}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_TICK, STATUS_DONE, 8'hAA, 1'b0},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'hAA, 1'b1}},
    '{1'b0, REG_EVAL_PERIOD, 8'd0, '{ACT_BL_ENABLE, STATUS_CHARGING, 8'hFF, 1'b0},
      4'd1, 1'b1, '{8'd0, 1'b0, 8'd0, 1'b0}}
  };

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cla_in_if  in_bus ();
  cla_out_if out_bus ();

  charge_led_animator_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state
  cfg_t       cfg_shadow;
  logic [7:0] tick_left;
  logic [7:0] anim_left;
  logic [7:0] fade_lvl;
  logic [7:0] charge_lvl;
  logic [7:0] bl_lvl;
  logic       bl_en;
  mode_t      led_mode;
  status_t    prev_status;

  res_t pending_levels [$];
  int   mismatch_count = 0;
  bit   in_quiet = 1'b0;
  bit   out_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  function automatic void reset_levels();
    cfg_shadow  = '{RST_EVAL_PERIOD, RST_FADE_STEP, RST_FADE_STEPS, RST_BLINK_COUNT,
                    RST_FADE_START_LEVEL, RST_DONE_LEVEL, RST_BLINK_LEVEL};
    tick_left   = RST_EVAL_PERIOD;
    anim_left   = RST_BLINK_COUNT;
    fade_lvl    = '0;
    charge_lvl  = '0;
    bl_lvl      = '0;
    bl_en       = 1'b0;
    led_mode    = MODE_OFF;
    prev_status = STATUS_OFF;
  endfunction

  function automatic res_t predict_levels(input item_t txn);
    res_t r;
    if (txn.action == ACT_BL_ENABLE) begin
      bl_en  = txn.backlight_enable;
      bl_lvl = txn.backlight_enable ? txn.backlight_request : 8'd0;
    end else begin
      tick_left = tick_left - 8'd1;
      if (tick_left == 8'd0) begin
        tick_left = cfg_shadow.eval_period;
        if (bl_en) bl_lvl = txn.backlight_request;
        if (txn.charge_status != prev_status) begin
          prev_status = status_t'(txn.charge_status);
          case (prev_status)
            STATUS_OFF: begin
              led_mode   = MODE_OFF;
              charge_lvl = 8'd0;
            end
            STATUS_CHARGING: begin
              led_mode   = MODE_FADE_UP;
              anim_left  = cfg_shadow.fade_steps;
              fade_lvl   = cfg_shadow.fade_start_level;
              charge_lvl = fade_lvl;
            end
            STATUS_DONE: begin
              led_mode   = MODE_DONE;
              charge_lvl = cfg_shadow.done_level;
            end
            default: begin
              led_mode   = MODE_BLINK_ON;
              anim_left  = cfg_shadow.blink_count;
              charge_lvl = cfg_shadow.blink_level;
            end
          endcase
        end
        // animation steps in the same evaluation
        case (led_mode)
          MODE_FADE_UP, MODE_FADE_DOWN: begin
            fade_lvl   = (led_mode == MODE_FADE_UP) ? fade_lvl + cfg_shadow.fade_step
                                                    : fade_lvl - cfg_shadow.fade_step;
            charge_lvl = fade_lvl;
            anim_left  = anim_left - 8'd1;
            if (anim_left == 8'd0) begin
              anim_left = cfg_shadow.fade_steps;
              led_mode  = (led_mode == MODE_FADE_UP) ? MODE_FADE_DOWN : MODE_FADE_UP;
            end
          end
          MODE_BLINK_ON: begin
            anim_left = anim_left - 8'd1;
            if (anim_left == 8'd0) begin
              led_mode   = MODE_BLINK_OFF;
              anim_left  = cfg_shadow.blink_count;
              charge_lvl = 8'd0;
            end
          end
          MODE_BLINK_OFF: begin
            anim_left = anim_left - 8'd1;
            if (anim_left == 8'd0) begin
              led_mode   = MODE_BLINK_ON;
              anim_left  = cfg_shadow.blink_count;
              charge_lvl = cfg_shadow.blink_level;
            end
          end
          default: begin
          end
        endcase
      end
    end
    r.charge_level    = charge_lvl;
    r.charge_on       = (charge_lvl != 8'd0);
    r.backlight_level = bl_lvl;
    r.backlight_on    = (bl_lvl != 8'd0);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input item_t txn, input logic use_typed, input res_t typed_res);
    int   gap;
    res_t pred;
    gap = in_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid             <= 1'b1;
    in_bus.action            <= txn.action;
    in_bus.charge_status     <= txn.charge_status;
    in_bus.backlight_request <= txn.backlight_request;
    in_bus.backlight_enable  <= txn.backlight_enable;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pred = predict_levels(txn);
    pending_levels.push_back(use_typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write then read back, block idle
  task automatic config_write(input reg_idx_t ridx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (ridx)
      REG_EVAL_PERIOD:      cfg_shadow.eval_period      = val;
      REG_FADE_STEP:        cfg_shadow.fade_step        = val;
      REG_FADE_STEPS:       cfg_shadow.fade_steps       = val;
      REG_BLINK_COUNT:      cfg_shadow.blink_count      = val;
      REG_FADE_START_LEVEL: cfg_shadow.fade_start_level = val;
      REG_DONE_LEVEL:       cfg_shadow.done_level       = val;
      default:              cfg_shadow.blink_level      = val;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("register readback", val, prdata[7:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    dir_row_t   row;
    item_t      txn;
    status_t    cur_status;
    reg_idx_t   ridx;
    logic [7:0] val;
    bit         is_count;
    int         ph;
    int         n;
    int         r;
    rst_n                    = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    in_bus.valid             = 1'b0;
    in_bus.action            = 1'b0;
    in_bus.charge_status     = '0;
    in_bus.backlight_request = '0;
    in_bus.backlight_enable  = 1'b0;
    cur_status               = STATUS_OFF;
    reset_levels();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < DIR_ROWS; n++) begin
      row = DIR_TABLE[n];
      if (row.is_write) begin
        drain_results();
        config_write(row.reg_sel, row.wval);
      end else begin
        repeat (row.reps) send_item(row.txn, row.has_exp, row.exp_res);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      for (r = 0; r < 7; r++) begin
        ridx     = reg_idx_t'(r);
        is_count = (ridx == REG_EVAL_PERIOD) || (ridx == REG_FADE_STEPS) ||
                   (ridx == REG_BLINK_COUNT);
        case (ph)
          0: val = 8'hFF;
          1: val = is_count ? 8'd1 : 8'd0;
          // zero counts behave as 256
          3: val = (ridx == REG_EVAL_PERIOD) ? 8'd1 :
                   is_count ? 8'd0 : 8'($urandom_range(0, 255));
          5: val = (ridx == REG_EVAL_PERIOD) ? 8'd0 :
                   is_count ? 8'($urandom_range(1, 4)) : 8'($urandom_range(0, 255));
          default: val = (ridx == REG_EVAL_PERIOD) ? 8'($urandom_range(1, 3)) :
                         is_count ? 8'($urandom_range(1, 8)) : 8'($urandom_range(0, 255));
        endcase
        config_write(ridx, val);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) in_quiet = ($urandom_range(0, 3) == 0);
        if (n == PHASE_ITEMS / 2) drain_results();
        // status mostly holds, with occasional changes
        if ($urandom_range(0, 7) == 0) cur_status = status_t'($urandom_range(0, 3));
        txn.action            = ($urandom_range(0, 5) == 0) ? ACT_BL_ENABLE : ACT_TICK;
        txn.charge_status     = cur_status;
        txn.backlight_request = 8'($urandom_range(0, 255));
        txn.backlight_enable  = 1'($urandom_range(0, 1));
        send_item(txn, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    res_t want;
    int   stall;
    int   accepted;
    out_bus.ready = 1'b0;
    accepted      = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (accepted % 32 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      stall = out_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      accepted++;
      if (pending_levels.size() == 0) begin
        mismatch_count++;
        $display("%0t: transaction with nothing expected, charge_level %0d backlight_level %0d",
                 $time, out_bus.charge_level, out_bus.backlight_level);
      end else begin
        want = pending_levels.pop_front();
        check_field("charge_level", want.charge_level, out_bus.charge_level);
        check_field("charge_on", 8'(want.charge_on), 8'(out_bus.charge_on));
        check_field("backlight_level", want.backlight_level, out_bus.backlight_level);
        check_field("backlight_on", 8'(want.backlight_on), 8'(out_bus.backlight_on));
      end
      @(negedge clk);
    end
  end

endmodule
